// ===== sv/dbit_pkg.sv =====
// shared types and constants for the interval-timing debouncer
// no dependencies; imported by debounce_with_interval_timing
package dbit_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned STIME_W = 16;
  localparam int unsigned OUT_TIME_W = 32;

  // word index of the single configuration register
  localparam logic REG_STABLE_TIME = 1'b0;

  localparam logic [STIME_W-1:0] STABLE_TIME_RESET = 16'd20;

  // one result request as held in the output buffer
  typedef struct packed {
    logic                  changed;
    logic                  level;
    logic                  previous_level;
    logic [OUT_TIME_W-1:0] previous_duration;
    logic [OUT_TIME_W-1:0] current_duration;
  } res_t;

endpackage

// ===== sv/debounce_with_interval_timing.sv =====
// time-based switch debouncer with confirmed-level interval timing
// depends on dbit_pkg; checked by dbit_checker (bound in its own file)

// Each request carries a millisecond timestamp and a sampled pin level and
// yields exactly one result. The block takes one request per clock while
// in_stall is low and registers each result in the output buffer; the debounce
// state (raw level, confirmed level and their change times) is updated in the
// same cycle a request is taken, so the subtract-and-compare on the timestamp
// is what sets the rate. A two-entry output buffer (output register
// plus skid register) keeps the input side taking requests while one result
// waits; in_stall rises only when both entries are full. The first request
// after reset primes the block: the confirmed level becomes the opposite of
// the pin and its start time is backdated by stable_time. stable_time lives at
// byte address 0 of the APB-style port and is read back there; timestamps wrap
// modulo 2^TIME_BITS and durations are reported in the low 32 bits.
module debounce_with_interval_timing #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dbit_pkg::ADDR_W-1:0]      paddr,
  input  logic [dbit_pkg::DATA_W-1:0]      pwdata,
  output logic [dbit_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [31:0]                      now_ms,
  input  logic                             pin_level,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             changed,
  output logic                             level,
  output logic                             previous_level,
  output logic [dbit_pkg::OUT_TIME_W-1:0]  previous_duration,
  output logic [dbit_pkg::OUT_TIME_W-1:0]  current_duration
);
  import dbit_pkg::*;

  // configuration
  logic [STIME_W-1:0]   stable_time;
  logic                 cfg_write;
  logic                 cfg_hit;

  // debounce state
  logic                 primed;
  logic                 raw_level;
  logic [TIME_BITS-1:0] raw_change_time;
  logic                 stable_level;
  logic                 prior_stable_level;
  logic [TIME_BITS-1:0] stable_change_time;
  logic [TIME_BITS-1:0] prior_duration;

  logic                 raw_level_next;
  logic [TIME_BITS-1:0] raw_change_time_next;
  logic                 stable_level_next;
  logic                 prior_stable_level_next;
  logic [TIME_BITS-1:0] stable_change_time_next;
  logic [TIME_BITS-1:0] prior_duration_next;

  // per-request evaluation
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] held;
  logic [TIME_BITS-1:0] cur_dur;
  logic                 confirm;
  logic                 accept;
  logic                 take;
  res_t                 res;

  // output buffer: main register drives the ports, skid catches overflow
  res_t                 main_res;
  res_t                 skid_res;
  logic                 main_valid;
  logic                 skid_valid;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_hit   = (paddr[2] == REG_STABLE_TIME);
  assign cfg_write = psel && penable && pwrite && pready && cfg_hit;

  // read back only the live register, zero elsewhere
  assign prdata = cfg_hit ? DATA_W'(stable_time) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_time <= STABLE_TIME_RESET;
    end else if (cfg_write) begin
      stable_time <= pwdata[STIME_W-1:0];
    end
  end

  // -------------------------------------------------------------- handshake
  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign take     = main_valid && !out_stall;

  // ---------------------------------------------------------- evaluation
  // timestamp folded to the timer width, all differences wrap there
  assign now_t = TIME_BITS'(now_ms);
  assign held  = now_t - raw_change_time;

  // a raw level that has held long enough and differs from the confirmed one
  assign confirm = (held >= TIME_BITS'(stable_time)) && (raw_level != stable_level);

  always_comb begin
    raw_level_next          = raw_level;
    raw_change_time_next    = raw_change_time;
    stable_level_next       = stable_level;
    prior_stable_level_next = prior_stable_level;
    stable_change_time_next = stable_change_time;
    prior_duration_next     = prior_duration;
    cur_dur                 = '0;
    if (!primed) begin
      // priming: confirmed level starts opposite the pin, backdated
      raw_level_next          = pin_level;
      raw_change_time_next    = now_t;
      stable_level_next       = ~pin_level;
      prior_stable_level_next = pin_level;
      stable_change_time_next = now_t - TIME_BITS'(stable_time);
    end else begin
      if (confirm) begin
        prior_stable_level_next = stable_level;
        stable_level_next       = raw_level;
        prior_duration_next     = raw_change_time - stable_change_time;
        stable_change_time_next = raw_change_time;
      end
      cur_dur = now_t - stable_change_time_next;
      // sample the pin only after the evaluation above
      if (pin_level != raw_level) begin
        raw_level_next       = pin_level;
        raw_change_time_next = now_t;
      end
    end
  end

  always_comb begin
    res.changed           = primed && confirm;
    res.level             = stable_level_next;
    res.previous_level    = prior_stable_level_next;
    res.previous_duration = OUT_TIME_W'(prior_duration_next);
    res.current_duration  = OUT_TIME_W'(cur_dur);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed             <= 1'b0;
      raw_level          <= 1'b0;
      raw_change_time    <= '0;
      stable_level       <= 1'b0;
      prior_stable_level <= 1'b0;
      stable_change_time <= '0;
      prior_duration     <= '0;
    end else if (accept) begin
      primed             <= 1'b1;
      raw_level          <= raw_level_next;
      raw_change_time    <= raw_change_time_next;
      stable_level       <= stable_level_next;
      prior_stable_level <= prior_stable_level_next;
      stable_change_time <= stable_change_time_next;
      prior_duration     <= prior_duration_next;
    end
  end

  // --------------------------------------------------------- output buffer
  // valid bits: a result goes to main when main is free or draining,
  // otherwise to skid; skid refills main as soon as main is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (main_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (take) begin
      main_valid <= 1'b0;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        main_res <= skid_res;
      end
    end else if (accept) begin
      if (main_valid && !take) begin
        skid_res <= res;
      end else begin
        main_res <= res;
      end
    end
  end

  assign out_valid         = main_valid;
  assign changed           = main_res.changed;
  assign level             = main_res.level;
  assign previous_level    = main_res.previous_level;
  assign previous_duration = main_res.previous_duration;
  assign current_duration  = main_res.current_duration;

endmodule

// ===== sv/dbit_checker.sv =====
// port-level checks for the interval-timing debouncer
// depends on debounce_with_interval_timing; attached by the bind below
module dbit_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        changed,
  input logic        level,
  input logic        previous_level,
  input logic [31:0] previous_duration,
  input logic [31:0] current_duration
);

  // the input side only backs up when a result is already waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("in_stall high with no result pending");

  // every taken request leaves a result on the output
  a_request_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("request taken but no result shown");

  // confirmed level always differs from the one it replaced
  a_level_toggles: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level != previous_level))
    else $error("confirmed level equals previous level");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(changed) && $stable(level)
      && $stable(previous_level) && $stable(previous_duration)
      && $stable(current_duration)))
    else $error("stalled result changed");

endmodule

bind debounce_with_interval_timing dbit_checker u_dbit_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .changed           (changed),
  .level             (level),
  .previous_level    (previous_level),
  .previous_duration (previous_duration),
  .current_duration  (current_duration)
);
